// File: hdl/xsc_pkg.sv
// Shared types, codes and field positions for the XMODEM sender control block.
`timescale 1ns / 1ps

package xsc_pkg;

   // Receiver bytes the sender reacts to.
   localparam logic [7:0] BYTE_ACK = 8'h06;
   localparam logic [7:0] BYTE_NAK = 8'h15;
   localparam logic [7:0] BYTE_CAN = 8'h18;
   localparam logic [7:0] BYTE_CRC = 8'h43;

   // Transfer modes.
   localparam logic [1:0] MODE_CHECKSUM = 2'd0;
   localparam logic [1:0] MODE_CRC      = 2'd1;
   localparam logic [1:0] MODE_1K       = 2'd2;
   localparam logic [1:0] MODE_1K_ALIAS = 2'd3;

   // Frame to send.
   localparam logic [1:0] SEND_NONE   = 2'd0;
   localparam logic [1:0] SEND_BLOCK  = 2'd1;
   localparam logic [1:0] SEND_EOT    = 2'd2;
   localparam logic [1:0] SEND_CANCEL = 2'd3;

   // Timer commands.
   localparam logic [1:0] TIMER_LEAVE   = 2'd0;
   localparam logic [1:0] TIMER_STOP    = 2'd1;
   localparam logic [1:0] TIMER_NORMAL  = 2'd2;
   localparam logic [1:0] TIMER_LONG    = 2'd3;

   // Phase codes as they appear on the result channel.
   localparam logic [2:0] PHASE_CODE_WAIT  = 3'd0;
   localparam logic [2:0] PHASE_CODE_BLOCK = 3'd1;
   localparam logic [2:0] PHASE_CODE_EOT   = 3'd2;
   localparam logic [2:0] PHASE_CODE_DONE  = 3'd3;
   localparam logic [2:0] PHASE_CODE_ERROR = 3'd4;

   // Error codes.
   localparam logic [2:0] ERR_NONE          = 3'd0;
   localparam logic [2:0] ERR_BLOCK_NAK     = 3'd1;
   localparam logic [2:0] ERR_BLOCK_CANCEL  = 3'd2;
   localparam logic [2:0] ERR_EOT_NAK       = 3'd3;
   localparam logic [2:0] ERR_EOT_CANCEL    = 3'd4;
   localparam logic [2:0] ERR_BLOCK_TIMEOUT = 3'd5;
   localparam logic [2:0] ERR_EOT_TIMEOUT   = 3'd6;

   // Register indexes on the configuration port.
   localparam logic [1:0] REG_START_MODE  = 2'd0;
   localparam logic [1:0] REG_DATA_LENGTH = 2'd1;
   localparam logic [1:0] REG_MAX_RETRIES = 2'd2;

   // Register reset values.
   localparam logic [1:0] START_MODE_RESET  = MODE_CRC;
   localparam int unsigned DATA_LENGTH_RESET = 1024;
   localparam logic [7:0] MAX_RETRIES_RESET = 8'd10;

   // Block sizes.
   localparam logic [10:0] BLOCK_SIZE_1K    = 11'd1024;
   localparam logic [10:0] BLOCK_SIZE_SHORT = 11'd128;

   // Highest block number before wrapping back to one.
   localparam logic [7:0] BLOCK_SEQ_LAST = 8'd255;

   // Result data layout, lowest bit first; bytes_done and error_code follow.
   localparam int SEND_LSB     = 0;
   localparam int TIMER_LSB    = 2;
   localparam int PHASE_LSB    = 4;
   localparam int MODE_LSB     = 7;
   localparam int DEGRADED_LSB = 9;
   localparam int SEQ_LSB      = 10;
   localparam int BYTES_LSB    = 18;

   // Transfer phase, one-hot.
   typedef enum logic [4:0] {
      PH_WAIT  = 5'b00001,
      PH_BLOCK = 5'b00010,
      PH_EOT   = 5'b00100,
      PH_DONE  = 5'b01000,
      PH_ERROR = 5'b10000
   } phase_type;

   // Configuration seen by the protocol engine.
   typedef struct packed {
      logic [1:0] start_mode;
      logic [7:0] max_retries;
      logic       mode_load;
      logic [1:0] mode_load_value;
   } csr_cfg_type;

   // Result of one transaction, without the progress count.
   typedef struct packed {
      logic [1:0] send_action;
      logic [1:0] timer_cmd;
      logic [2:0] phase_now;
      logic [1:0] mode_now;
      logic       mode_degraded;
      logic [7:0] block_seq;
      logic [2:0] error_code;
   } step_result_type;

   // Selector value three behaves as one-kilobyte mode.
   function automatic logic [1:0] clamp_mode(input logic [1:0] mode);
      clamp_mode = (mode == MODE_1K_ALIAS) ? MODE_1K : mode;
   endfunction

   // One-hot phase to its result code.
   function automatic logic [2:0] phase_code(input phase_type ph);
      logic [2:0] code;
      unique case (ph)
         PH_WAIT:  code = PHASE_CODE_WAIT;
         PH_BLOCK: code = PHASE_CODE_BLOCK;
         PH_EOT:   code = PHASE_CODE_EOT;
         PH_DONE:  code = PHASE_CODE_DONE;
         PH_ERROR: code = PHASE_CODE_ERROR;
         default:  code = PHASE_CODE_ERROR;
      endcase
      phase_code = code;
   endfunction

endpackage

// File: hdl/xmodem_sender_control.sv
// Path: an accepted transaction is held in the input register; its result then moves into the
// result register whenever that register is empty or its result is being taken.
// Throughput: one transaction per cycle unless results stall; the state update is single-stage.
// With the result side holding tready low, the input register takes at most one more transaction.
// Reset: synchronous, active high; clears valids, sets phase to wait start, block number
// to one, progress and retries to zero, and the registers to their documented defaults.
`timescale 1ns / 1ps

module xmodem_sender_control #(
   parameter int LENGTH_BITS = 24
) (
   input  logic                 clock,
   input  logic                 reset,
   // Request channel.
   input  logic                 req_tvalid,
   output logic                 req_tready,
   input  logic [7:0]           req_tdata,   // [7:0] rx_byte
   input  logic [0:0]           req_tuser,   // [0] req_type (1 = timeout tick)
   // Result channel.
   output logic                 rsp_tvalid,
   input  logic                 rsp_tready,
   // [1:0] send_action, [3:2] timer_cmd, [6:4] phase_now, [8:7] mode_now,
   // [9] mode_degraded, [17:10] block_seq, then bytes_done, error_code, zero pad.
   output logic [((21+LENGTH_BITS+7)/8)*8-1:0] rsp_tdata,
   // Configuration port.
   input  logic                 csr_psel,
   input  logic                 csr_penable,
   input  logic                 csr_pwrite,
   input  logic [3:0]           csr_paddr,
   input  logic [31:0]          csr_pwdata,
   output logic [31:0]          csr_prdata,
   output logic                 csr_pready
);

   localparam int RSP_W   = ((21 + LENGTH_BITS + 7) / 8) * 8;
   localparam int ERR_LSB = xsc_pkg::BYTES_LSB + LENGTH_BITS;
   localparam int PAD_W   = RSP_W - ERR_LSB - 3;

   xsc_pkg::csr_cfg_type     cfg;
   xsc_pkg::step_result_type result;
   logic [LENGTH_BITS-1:0]   data_length;
   logic [LENGTH_BITS-1:0]   bytes_done;

   logic                     req_valid_ff, req_valid_in;
   logic                     req_tick_ff;
   logic [7:0]               req_byte_ff;
   logic                     rsp_valid_ff, rsp_valid_in;
   logic [RSP_W-1:0]         rsp_data_ff;
   logic                     advance;
   logic                     step;
   logic                     req_fire;

   xsc_csr #(
      .LENGTH_BITS (LENGTH_BITS)
   ) u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .cfg         (cfg),
      .data_length (data_length)
   );

   xsc_engine #(
      .LENGTH_BITS (LENGTH_BITS)
   ) u_engine (
      .clock       (clock),
      .reset       (reset),
      .step        (step),
      .tick        (req_tick_ff),
      .rx_byte     (req_byte_ff),
      .cfg         (cfg),
      .data_length (data_length),
      .result      (result),
      .bytes_done  (bytes_done)
   );

   // Pipeline control: the result register moves when empty or taken.
   assign advance    = !rsp_valid_ff || rsp_tready;
   assign step       = req_valid_ff && advance;
   assign req_tready = !req_valid_ff || advance;
   assign req_fire   = req_tvalid && req_tready;

   always_comb begin
      req_valid_in = req_valid_ff;
      rsp_valid_in = rsp_valid_ff;
      if (req_tready) begin
         req_valid_in = req_tvalid;
      end
      if (advance) begin
         rsp_valid_in = req_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         req_valid_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         req_valid_ff <= req_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Input register.
   always_ff @(posedge clock) begin
      if (req_fire) begin
         req_tick_ff <= req_tuser[0];
         req_byte_ff <= req_tdata;
      end
   end

   // Result register.
   always_ff @(posedge clock) begin
      if (step) begin
         rsp_data_ff <= {{PAD_W{1'b0}}, result.error_code, bytes_done,
                         result.block_seq, result.mode_degraded, result.mode_now,
                         result.phase_now, result.timer_cmd, result.send_action};
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

endmodule

// File: hdl/xsc_csr.sv
// Configuration registers behind the APB-style port.
`timescale 1ns / 1ps

module xsc_csr #(
   parameter int LENGTH_BITS = 24
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     csr_psel,
   input  logic                     csr_penable,
   input  logic                     csr_pwrite,
   input  logic [3:0]               csr_paddr,
   input  logic [31:0]              csr_pwdata,
   output logic [31:0]              csr_prdata,
   output logic                     csr_pready,
   output xsc_pkg::csr_cfg_type     cfg,
   output logic [LENGTH_BITS-1:0]   data_length
);

   logic [1:0]             start_mode_ff, start_mode_in;
   logic [LENGTH_BITS-1:0] data_length_ff, data_length_in;
   logic [7:0]             max_retries_ff, max_retries_in;
   logic                   wr_en;
   logic [1:0]             reg_index;

   assign csr_pready = 1'b1;
   assign reg_index  = csr_paddr[3:2];
   assign wr_en      = csr_psel && csr_penable && csr_pwrite && csr_pready;

   // Register write decode.
   always_comb begin
      start_mode_in  = start_mode_ff;
      data_length_in = data_length_ff;
      max_retries_in = max_retries_ff;
      if (wr_en) begin
         unique case (reg_index)
            xsc_pkg::REG_START_MODE:  start_mode_in  = csr_pwdata[1:0];
            xsc_pkg::REG_DATA_LENGTH: data_length_in = csr_pwdata[LENGTH_BITS-1:0];
            xsc_pkg::REG_MAX_RETRIES: max_retries_in = csr_pwdata[7:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         start_mode_ff  <= xsc_pkg::START_MODE_RESET;
         data_length_ff <= LENGTH_BITS'(xsc_pkg::DATA_LENGTH_RESET);
         max_retries_ff <= xsc_pkg::MAX_RETRIES_RESET;
      end else begin
         start_mode_ff  <= start_mode_in;
         data_length_ff <= data_length_in;
         max_retries_ff <= max_retries_in;
      end
   end

   // Read mux.
   always_comb begin
      unique case (reg_index)
         xsc_pkg::REG_START_MODE:  csr_prdata = {30'd0, start_mode_ff};
         xsc_pkg::REG_DATA_LENGTH: csr_prdata = 32'(data_length_ff);
         xsc_pkg::REG_MAX_RETRIES: csr_prdata = {24'd0, max_retries_ff};
         default:                  csr_prdata = 32'd0;
      endcase
   end

   // A start mode write also reloads the active mode while waiting for the receiver.
   assign cfg.start_mode      = start_mode_ff;
   assign cfg.max_retries     = max_retries_ff;
   assign cfg.mode_load       = wr_en && (reg_index == xsc_pkg::REG_START_MODE);
   assign cfg.mode_load_value = csr_pwdata[1:0];
   assign data_length         = data_length_ff;

endmodule

// File: hdl/xsc_engine.sv
// Protocol state and the single-step update for one received byte or tick.
`timescale 1ns / 1ps

module xsc_engine #(
   parameter int LENGTH_BITS = 24
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          step,
   input  logic                          tick,
   input  logic [7:0]                    rx_byte,
   input  xsc_pkg::csr_cfg_type          cfg,
   input  logic [LENGTH_BITS-1:0]        data_length,
   output xsc_pkg::step_result_type      result,
   output logic [LENGTH_BITS-1:0]        bytes_done
);

   localparam int CW = (LENGTH_BITS > 11) ? LENGTH_BITS : 11;

   xsc_pkg::phase_type     phase_ff, phase_in;
   logic [1:0]             mode_ff, mode_in;
   logic [7:0]             seq_ff, seq_in;
   logic [LENGTH_BITS-1:0] acked_ff, acked_in;
   logic [7:0]             retry_ff, retry_in;

   logic [1:0]             send;
   logic [1:0]             timer;
   logic                   degraded;
   logic [2:0]             err;

   logic [8:0]             retry_next;
   logic                   retry_over;
   logic [10:0]            block_size;
   logic [LENGTH_BITS-1:0] remain;
   logic [CW-1:0]          remain_ext;
   logic [CW-1:0]          size_ext;
   logic [CW-1:0]          add_ext;
   logic                   last_block;

   // Retry count check shared by NAK and tick.
   assign retry_next = {1'b0, retry_ff} + 9'd1;
   assign retry_over = retry_next > {1'b0, cfg.max_retries};

   // Progress on ACK: add the smaller of block size and what is left.
   assign block_size = (mode_ff == xsc_pkg::MODE_1K) ? xsc_pkg::BLOCK_SIZE_1K
                                                     : xsc_pkg::BLOCK_SIZE_SHORT;
   assign remain     = (acked_ff < data_length) ? (data_length - acked_ff)
                                                : '0;
   assign remain_ext = CW'(remain);
   assign size_ext   = CW'(block_size);
   assign last_block = remain_ext <= size_ext;
   assign add_ext    = last_block ? remain_ext : size_ext;

   // Next state and result for the transaction in the input register.
   always_comb begin
      phase_in = phase_ff;
      mode_in  = mode_ff;
      seq_in   = seq_ff;
      acked_in = acked_ff;
      retry_in = retry_ff;
      send     = xsc_pkg::SEND_NONE;
      timer    = xsc_pkg::TIMER_LEAVE;
      degraded = 1'b0;
      err      = xsc_pkg::ERR_NONE;

      unique case (phase_ff) inside
         xsc_pkg::PH_WAIT: begin
            if (tick) begin
               timer = xsc_pkg::TIMER_LONG;
            end else if (rx_byte == xsc_pkg::BYTE_NAK || rx_byte == xsc_pkg::BYTE_CRC) begin
               if (rx_byte == xsc_pkg::BYTE_NAK && mode_ff != xsc_pkg::MODE_CHECKSUM) begin
                  mode_in  = xsc_pkg::MODE_CHECKSUM;
                  degraded = 1'b1;
               end
               retry_in = '0;
               phase_in = xsc_pkg::PH_BLOCK;
               send     = xsc_pkg::SEND_BLOCK;
               timer    = xsc_pkg::TIMER_NORMAL;
            end
         end

         xsc_pkg::PH_BLOCK, xsc_pkg::PH_EOT: begin
            if (tick || rx_byte == xsc_pkg::BYTE_NAK) begin
               // Retransmit, or give up once the retry limit is passed.
               if (retry_over) begin
                  send     = xsc_pkg::SEND_CANCEL;
                  phase_in = xsc_pkg::PH_ERROR;
                  if (tick) begin
                     err = (phase_ff == xsc_pkg::PH_BLOCK) ? xsc_pkg::ERR_BLOCK_TIMEOUT
                                                           : xsc_pkg::ERR_EOT_TIMEOUT;
                  end else begin
                     timer = xsc_pkg::TIMER_STOP;
                     err   = (phase_ff == xsc_pkg::PH_BLOCK) ? xsc_pkg::ERR_BLOCK_NAK
                                                             : xsc_pkg::ERR_EOT_NAK;
                  end
               end else begin
                  retry_in = retry_next[7:0];
                  send     = (phase_ff == xsc_pkg::PH_BLOCK) ? xsc_pkg::SEND_BLOCK
                                                             : xsc_pkg::SEND_EOT;
                  timer    = xsc_pkg::TIMER_NORMAL;
               end
            end else if (rx_byte == xsc_pkg::BYTE_ACK) begin
               if (phase_ff == xsc_pkg::PH_BLOCK) begin
                  retry_in = '0;
                  seq_in   = (seq_ff >= xsc_pkg::BLOCK_SEQ_LAST) ? 8'd1 : seq_ff + 8'd1;
                  acked_in = acked_ff + LENGTH_BITS'(add_ext);
                  timer    = xsc_pkg::TIMER_NORMAL;
                  if (last_block) begin
                     phase_in = xsc_pkg::PH_EOT;
                     send     = xsc_pkg::SEND_EOT;
                  end else begin
                     send     = xsc_pkg::SEND_BLOCK;
                  end
               end else begin
                  timer    = xsc_pkg::TIMER_STOP;
                  phase_in = xsc_pkg::PH_DONE;
               end
            end else if (rx_byte == xsc_pkg::BYTE_CAN) begin
               timer    = xsc_pkg::TIMER_STOP;
               phase_in = xsc_pkg::PH_ERROR;
               err      = (phase_ff == xsc_pkg::PH_BLOCK) ? xsc_pkg::ERR_BLOCK_CANCEL
                                                          : xsc_pkg::ERR_EOT_CANCEL;
            end
         end

         xsc_pkg::PH_DONE, xsc_pkg::PH_ERROR: ;

         default: ;
      endcase
   end

   // State registers; a start mode write reloads the mode only while waiting.
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= xsc_pkg::PH_WAIT;
         mode_ff  <= xsc_pkg::clamp_mode(xsc_pkg::START_MODE_RESET);
         seq_ff   <= 8'd1;
         acked_ff <= '0;
         retry_ff <= '0;
      end else if (step) begin
         phase_ff <= phase_in;
         mode_ff  <= mode_in;
         seq_ff   <= seq_in;
         acked_ff <= acked_in;
         retry_ff <= retry_in;
      end else if (cfg.mode_load && phase_ff == xsc_pkg::PH_WAIT) begin
         mode_ff  <= xsc_pkg::clamp_mode(cfg.mode_load_value);
      end
   end

   assign result.send_action   = send;
   assign result.timer_cmd     = timer;
   assign result.phase_now     = xsc_pkg::phase_code(phase_in);
   assign result.mode_now      = mode_in;
   assign result.mode_degraded = degraded;
   assign result.block_seq     = seq_in;
   assign result.error_code    = err;
   assign bytes_done           = acked_in;

endmodule

// File: hdl/xsc_checker.sv
// Port-level checks for the XMODEM sender control block, bound to the top level.
`timescale 1ns / 1ps

module xsc_checker #(
   parameter int LENGTH_BITS = 24
) (
   input logic                                  clock,
   input logic                                  reset,
   input logic                                  rsp_tvalid,
   input logic                                  rsp_tready,
   input logic [((21+LENGTH_BITS+7)/8)*8-1:0]   rsp_tdata
);

   localparam int ERR_LSB = xsc_pkg::BYTES_LSB + LENGTH_BITS;

   logic [1:0] send_action;
   logic [2:0] phase_now;
   logic [1:0] mode_now;
   logic       mode_degraded;
   logic [2:0] error_code;

   assign send_action   = rsp_tdata[xsc_pkg::SEND_LSB +: 2];
   assign phase_now     = rsp_tdata[xsc_pkg::PHASE_LSB +: 3];
   assign mode_now      = rsp_tdata[xsc_pkg::MODE_LSB +: 2];
   assign mode_degraded = rsp_tdata[xsc_pkg::DEGRADED_LSB];
   assign error_code    = rsp_tdata[ERR_LSB +: 3];

   // A stalled result transaction keeps its data.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> $stable(rsp_tdata))
      else $error("result data changed while stalled");

   // No result is shown in the cycle after reset.
   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("result valid right after reset");

   // An error code is reported only on entry to the error phase.
   a_err_phase: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && error_code != xsc_pkg::ERR_NONE |-> phase_now == xsc_pkg::PHASE_CODE_ERROR)
      else $error("error code outside error phase");

   // Cancel bytes are sent only together with an error code.
   a_cancel_err: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && send_action == xsc_pkg::SEND_CANCEL |-> error_code != xsc_pkg::ERR_NONE)
      else $error("cancel sent without an error code");

   // A mode drop switches to checksum mode and starts the block phase.
   a_degrade: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && mode_degraded |->
         mode_now == xsc_pkg::MODE_CHECKSUM && phase_now == xsc_pkg::PHASE_CODE_BLOCK)
      else $error("mode drop with wrong mode or phase");

endmodule

bind xmodem_sender_control xsc_checker #(
   .LENGTH_BITS (LENGTH_BITS)
) u_xsc_checker (
   .clock      (clock),
   .reset      (reset),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata)
);

// File: verif/tb_xmodem_sender_control.sv
// Self-checking testbench for the XMODEM sender control block.
`timescale 1ns / 1ps

module tb_xmodem_sender_control;
   import xsc_pkg::*;

   localparam int LEN_W          = 24;
   localparam int RSP_W          = ((21 + LEN_W + 7) / 8) * 8;
   localparam int ERR_LSB        = BYTES_LSB + LEN_W;
   localparam int QUIET_LIMIT    = 4000;
   localparam int HOLDOFF_CYCLES = 64;
   localparam int PRINT_LIMIT    = 100;

   logic             clock;
   logic             reset;
   logic             req_tvalid;
   logic             req_tready;
   logic [7:0]       req_tdata;   // [7:0] rx_byte
   logic [0:0]       req_tuser;   // [0] req_type (1 = timeout tick)
   logic             rsp_tvalid;
   logic             rsp_tready;
   // [1:0] send_action, [3:2] timer_cmd, [6:4] phase_now, [8:7] mode_now,
   // [9] mode_degraded, [17:10] block_seq, [41:18] bytes_done, [44:42] error_code.
   logic [RSP_W-1:0] rsp_tdata;
   logic             csr_psel;
   logic             csr_penable;
   logic             csr_pwrite;
   logic [3:0]       csr_paddr;
   logic [31:0]      csr_pwdata;
   logic [31:0]      csr_prdata;
   logic             csr_pready;

   // Status the block reports for one transaction.
   typedef struct packed {
      logic [1:0]       send_action;
      logic [1:0]       timer_cmd;
      logic [2:0]       phase_now;
      logic [1:0]       mode_now;
      logic             mode_degraded;
      logic [7:0]       block_seq;
      logic [LEN_W-1:0] bytes_done;
      logic [2:0]       error_code;
   } xfer_status_type;

   // Tracks the transfer state and the expected status of every accepted transaction.
   class sender_status_board;
      logic [1:0]       start_mode_reg;
      logic [LEN_W-1:0] length_reg;
      logic [7:0]       retry_limit;
      logic [2:0]       phase;
      logic [1:0]       mode;
      logic [7:0]       block_seq;
      logic [LEN_W-1:0] acked;
      logic [7:0]       retries;
      logic [2:0]       last_error;
      xfer_status_type  expected_q[$];
      int               mismatches;
      int               checked;
      int               accepted;
      int               wraps;

      function new();
         start_mode_reg = START_MODE_RESET;
         length_reg     = DATA_LENGTH_RESET;
         retry_limit    = MAX_RETRIES_RESET;
         phase          = PHASE_CODE_WAIT;
         mode           = effective_mode(START_MODE_RESET);
         block_seq      = 8'd1;
         acked          = '0;
         retries        = 8'd0;
         last_error     = ERR_NONE;
         mismatches     = 0;
         checked        = 0;
         accepted       = 0;
         wraps          = 0;
      endfunction

      // The alias selector behaves as one-kilobyte mode.
      function logic [1:0] effective_mode(logic [1:0] sel);
         return (sel == MODE_1K_ALIAS) ? MODE_1K : sel;
      endfunction

      // Counts one more retry; reports when that would go past the limit.
      function bit retry_exhausted();
         int unsigned next_count;
         next_count = retries + 1;
         if (next_count > retry_limit)
            return 1'b1;
         retries = 8'(next_count);
         return 1'b0;
      endfunction

      function void write_register(logic [1:0] index, logic [31:0] value);
         case (index)
            REG_START_MODE: begin
               start_mode_reg = value[1:0];
               // Only a transfer that has not started picks up the new mode.
               if (phase == PHASE_CODE_WAIT)
                  mode = effective_mode(value[1:0]);
            end
            REG_DATA_LENGTH: begin
               length_reg = value[LEN_W-1:0];
            end
            REG_MAX_RETRIES: begin
               retry_limit = value[7:0];
            end
            default: begin
            end
         endcase
      endfunction

      // Advances the transfer state for one accepted transaction.
      function void note_request(logic tick, logic [7:0] b);
         xfer_status_type s;
         logic [1:0]   send;
         logic [1:0]   timer;
         logic         degraded;
         logic [2:0]   err;
         logic         in_block;
         int unsigned  block_bytes;
         int unsigned  remaining;
         send     = SEND_NONE;
         timer    = TIMER_LEAVE;
         degraded = 1'b0;
         err      = ERR_NONE;
         in_block = (phase == PHASE_CODE_BLOCK);
         accepted++;
         if (tick) begin
            if (phase == PHASE_CODE_BLOCK || phase == PHASE_CODE_EOT) begin
               if (retry_exhausted()) begin
                  // The timer has already fired, so it is left alone.
                  send  = SEND_CANCEL;
                  err   = in_block ? ERR_BLOCK_TIMEOUT : ERR_EOT_TIMEOUT;
                  phase = PHASE_CODE_ERROR;
               end else begin
                  send  = in_block ? SEND_BLOCK : SEND_EOT;
                  timer = TIMER_NORMAL;
               end
            end else if (phase == PHASE_CODE_WAIT) begin
               timer = TIMER_LONG;
            end
         end else if (phase == PHASE_CODE_WAIT) begin
            if (b == BYTE_NAK || b == BYTE_CRC) begin
               // A NAK asks for plain checksum mode.
               if (b == BYTE_NAK && mode != MODE_CHECKSUM) begin
                  mode     = MODE_CHECKSUM;
                  degraded = 1'b1;
               end
               retries = 8'd0;
               phase   = PHASE_CODE_BLOCK;
               send    = SEND_BLOCK;
               timer   = TIMER_NORMAL;
            end
         end else if (phase == PHASE_CODE_BLOCK || phase == PHASE_CODE_EOT) begin
            if (b == BYTE_ACK) begin
               if (in_block) begin
                  block_bytes = (mode == MODE_1K) ? BLOCK_SIZE_1K : BLOCK_SIZE_SHORT;
                  remaining   = (acked < length_reg) ? length_reg - acked : 0;
                  retries     = 8'd0;
                  if (block_seq >= BLOCK_SEQ_LAST) begin
                     block_seq = 8'd1;
                     wraps++;
                  end else begin
                     block_seq = block_seq + 8'd1;
                  end
                  acked = acked + ((block_bytes < remaining) ? block_bytes : remaining);
                  if (acked >= length_reg) begin
                     phase = PHASE_CODE_EOT;
                     send  = SEND_EOT;
                  end else begin
                     send = SEND_BLOCK;
                  end
                  timer = TIMER_NORMAL;
               end else begin
                  timer = TIMER_STOP;
                  phase = PHASE_CODE_DONE;
               end
            end else if (b == BYTE_NAK) begin
               if (retry_exhausted()) begin
                  send  = SEND_CANCEL;
                  timer = TIMER_STOP;
                  err   = in_block ? ERR_BLOCK_NAK : ERR_EOT_NAK;
                  phase = PHASE_CODE_ERROR;
               end else begin
                  send  = in_block ? SEND_BLOCK : SEND_EOT;
                  timer = TIMER_NORMAL;
               end
            end else if (b == BYTE_CAN) begin
               timer = TIMER_STOP;
               err   = in_block ? ERR_BLOCK_CANCEL : ERR_EOT_CANCEL;
               phase = PHASE_CODE_ERROR;
            end
         end
         if (err != ERR_NONE)
            last_error = err;
         s.send_action   = send;
         s.timer_cmd     = timer;
         s.phase_now     = phase;
         s.mode_now      = mode;
         s.mode_degraded = degraded;
         s.block_seq     = block_seq;
         s.bytes_done    = acked;
         s.error_code    = err;
         expected_q.push_back(s);
      endfunction

      task report_mismatch(string msg);
         mismatches++;
         if (mismatches <= PRINT_LIMIT)
            $display("MISMATCH at %0t: %s", $realtime, msg);
      endtask

      // Compares one result transaction with the oldest expected status.
      task check_status(logic [RSP_W-1:0] d);
         xfer_status_type want;
         string        diffs;
         if (expected_q.size() == 0) begin
            report_mismatch("result transaction with no status expected");
            return;
         end
         want = expected_q.pop_front();
         checked++;
         diffs = "";
         if (d[SEND_LSB +: 2] !== want.send_action)
            diffs = {diffs, $sformatf(" send_action %0d/%0d", d[SEND_LSB +: 2], want.send_action)};
         if (d[TIMER_LSB +: 2] !== want.timer_cmd)
            diffs = {diffs, $sformatf(" timer_cmd %0d/%0d", d[TIMER_LSB +: 2], want.timer_cmd)};
         if (d[PHASE_LSB +: 3] !== want.phase_now)
            diffs = {diffs, $sformatf(" phase_now %0d/%0d", d[PHASE_LSB +: 3], want.phase_now)};
         if (d[MODE_LSB +: 2] !== want.mode_now)
            diffs = {diffs, $sformatf(" mode_now %0d/%0d", d[MODE_LSB +: 2], want.mode_now)};
         if (d[DEGRADED_LSB] !== want.mode_degraded)
            diffs = {diffs, $sformatf(" mode_degraded %0d/%0d", d[DEGRADED_LSB],
                                      want.mode_degraded)};
         if (d[SEQ_LSB +: 8] !== want.block_seq)
            diffs = {diffs, $sformatf(" block_seq %0d/%0d", d[SEQ_LSB +: 8], want.block_seq)};
         if (d[BYTES_LSB +: LEN_W] !== want.bytes_done)
            diffs = {diffs, $sformatf(" bytes_done %0d/%0d", d[BYTES_LSB +: LEN_W],
                                      want.bytes_done)};
         if (d[ERR_LSB +: 3] !== want.error_code)
            diffs = {diffs, $sformatf(" error_code %0d/%0d", d[ERR_LSB +: 3], want.error_code)};
         if (diffs != "")
            report_mismatch($sformatf("result %0d (got/want):%s", checked, diffs));
      endtask
   endclass

   sender_status_board board;
   int   tx_idle_pct;
   int   rx_idle_pct;
   int   holdoff_requests;
   int   holdoff_served;
   int   holdoff_left;
   int   quiet_cycles;
   logic moved;

   xmodem_sender_control dut (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tuser   (req_tuser),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   always #1 clock = ~clock;

   // Result side: random stalls, plus a long hold-off whenever one is requested.
   always @(posedge clock) begin
      if (holdoff_left > 0) begin
         rsp_tready   <= 1'b0;
         holdoff_left <= holdoff_left - 1;
      end else if (holdoff_served != holdoff_requests) begin
         holdoff_served <= holdoff_requests;
         holdoff_left   <= HOLDOFF_CYCLES;
         rsp_tready     <= 1'b0;
      end else begin
         rsp_tready <= ($urandom_range(99) >= rx_idle_pct);
      end
   end

   // Monitor both channels and watch for a stuck run.
   always @(posedge clock) begin
      if (reset) begin
         quiet_cycles <= 0;
      end else begin
         moved = 1'b0;
         if (req_tvalid && req_tready) begin
            board.note_request(req_tuser[0], req_tdata);
            moved = 1'b1;
         end
         if (rsp_tvalid && rsp_tready) begin
            board.check_status(rsp_tdata);
            moved = 1'b1;
         end
         if (csr_psel && csr_penable && csr_pwrite && csr_pready)
            moved = 1'b1;
         if (moved) begin
            quiet_cycles <= 0;
         end else if (quiet_cycles + 1 >= QUIET_LIMIT) begin
            $display("Watchdog expired after %0d quiet cycles", QUIET_LIMIT);
            $display("Verification failed");
            $finish;
         end else begin
            quiet_cycles <= quiet_cycles + 1;
         end
      end
   end

   // Any byte the sender ignores in the current phase; CRC is ignored once a transfer runs.
   function automatic logic [7:0] noise_byte(input bit allow_crc);
      logic [7:0] b;
      b = 8'($urandom_range(0, 255));
      while (b == BYTE_ACK || b == BYTE_NAK || b == BYTE_CAN || (!allow_crc && b == BYTE_CRC))
         b = 8'($urandom_range(0, 255));
      return b;
   endfunction

   // Offers one request transaction and returns at the edge that accepts it.
   task automatic send_item(input logic tick, input logic [7:0] b);
      while ($urandom_range(99) < tx_idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid   <= 1'b1;
      req_tdata    <= b;
      req_tuser[0] <= tick;
      @(posedge clock);
      while (!req_tready)
         @(posedge clock);
   endtask

   // A NAK or a timeout tick, both of which count as a retry.
   task automatic send_retry_trigger();
      if ($urandom_range(0, 1))
         send_item(1'b0, BYTE_NAK);
      else
         send_item(1'b1, 8'($urandom_range(0, 255)));
   endtask

   // Stops offering and waits until every expected status has come back.
   task automatic wait_drained();
      req_tvalid <= 1'b0;
      // One edge first, so the monitor has logged the last accepted transaction.
      @(posedge clock);
      while (board.expected_q.size() != 0)
         @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic csr_write(input logic [1:0] index, input logic [31:0] value);
      @(posedge clock);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= {index, 2'b00};
      csr_pwdata  <= value;
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      while (!csr_pready)
         @(posedge clock);
      board.write_register(index, value);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
   endtask

   // Mostly ACKs with NAKs and ticks in between; the retry count never passes the limit.
   task automatic run_transfer_traffic(input int count);
      int sent;
      int bumps;
      int pick;
      sent  = 0;
      bumps = board.retries;
      while (sent < count) begin
         pick = $urandom_range(99);
         if (bumps >= board.retry_limit || pick < 45) begin
            send_item(1'b0, BYTE_ACK);
            bumps = 0;
            sent++;
         end else if (pick < 65) begin
            send_item(1'b0, BYTE_NAK);
            bumps++;
            sent++;
         end else if (pick < 80) begin
            send_item(1'b1, 8'($urandom_range(0, 255)));
            bumps++;
            sent++;
         end else begin
            send_item(1'b0, noise_byte(1'b1));
            sent++;
         end
      end
   endtask

   initial begin : main_flow
      logic [2:0]       ending;
      logic             to_eot;
      logic             limit_ending;
      logic [LEN_W-1:0] target_length;
      int               bumps;

      clock            = 1'b0;
      reset            = 1'b1;
      req_tvalid       = 1'b0;
      req_tdata        = 8'h00;
      req_tuser        = 1'b0;
      rsp_tready       = 1'b0;
      csr_psel         = 1'b0;
      csr_penable      = 1'b0;
      csr_pwrite       = 1'b0;
      csr_paddr        = 4'h0;
      csr_pwdata       = 32'h0;
      tx_idle_pct      = 0;
      rx_idle_pct      = 0;
      holdoff_requests = 0;
      holdoff_served   = 0;
      holdoff_left     = 0;
      quiet_cycles     = 0;
      board            = new();

      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Waiting for the receiver: ticks and bytes that must not start the transfer.
      send_item(1'b1, 8'hA5);
      send_item(1'b0, 8'h00);
      send_item(1'b0, 8'hFF);
      send_item(1'b0, BYTE_ACK);
      send_item(1'b0, BYTE_CAN);
      send_item(1'b0, noise_byte(1'b0));
      wait_drained();

      // The alias mode selector, the longest image and the highest retry limit.
      csr_write(REG_START_MODE, {30'($urandom), MODE_1K_ALIAS});
      csr_write(REG_DATA_LENGTH, {8'($urandom), 24'hFFFFFF});
      csr_write(REG_MAX_RETRIES, {24'($urandom), 8'd255});
      send_item(1'b1, 8'h00);
      send_item(1'b0, 8'h5A);
      wait_drained();

      // Start the transfer in a random mode, by NAK or by CRC request.
      csr_write(REG_START_MODE, 32'($urandom_range(0, 3)));
      send_item(1'b0, $urandom_range(0, 1) ? BYTE_NAK : BYTE_CRC);
      send_item(1'b0, BYTE_NAK);
      send_item(1'b1, 8'hFF);
      send_item(1'b0, BYTE_CRC);
      send_item(1'b0, 8'h55);
      send_item(1'b0, BYTE_ACK);
      send_item(1'b0, BYTE_ACK);
      send_item(1'b1, 8'h00);
      send_item(1'b0, BYTE_ACK);
      wait_drained();

      // Sender idles often, receiver stalls most of the time.
      csr_write(REG_START_MODE, $urandom);
      tx_idle_pct = 34;
      rx_idle_pct = 87;
      run_transfer_traffic(400);
      wait_drained();

      // Tight retry limit and a shorter image; idling the other way round.
      csr_write(REG_MAX_RETRIES, 32'($urandom_range(1, 4)));
      csr_write(REG_DATA_LENGTH, 32'hFFFFFF - 32'($urandom_range(0, 8000000)));
      csr_write(REG_START_MODE, $urandom);
      tx_idle_pct = 87;
      rx_idle_pct = 34;
      run_transfer_traffic(400);
      wait_drained();

      // Full rate, with one long receiver hold-off in the middle to back up the input.
      csr_write(REG_MAX_RETRIES, 32'($urandom_range(5, 254)));
      tx_idle_pct = 0;
      rx_idle_pct = 0;
      run_transfer_traffic(200);
      holdoff_requests++;
      run_transfer_traffic(200);
      wait_drained();

      // Close the transfer with one of its endings, chosen at random.
      ending       = 3'($urandom_range(0, 6));
      to_eot       = (ending == ERR_NONE || ending == ERR_EOT_NAK ||
                      ending == ERR_EOT_CANCEL || ending == ERR_EOT_TIMEOUT);
      limit_ending = (ending == ERR_BLOCK_NAK || ending == ERR_EOT_NAK ||
                      ending == ERR_BLOCK_TIMEOUT || ending == ERR_EOT_TIMEOUT);
      tx_idle_pct  = 34;
      rx_idle_pct  = 87;
      if (to_eot) begin
         // The length may drop to zero, to below or to the acknowledged count, or just past it.
         case ($urandom_range(0, 3))
            0:       target_length = '0;
            1:       target_length = board.acked >> 1;
            2:       target_length = board.acked;
            default: target_length = board.acked + LEN_W'($urandom_range(1, 2000));
         endcase
         csr_write(REG_DATA_LENGTH, {8'($urandom), target_length});
         while (board.phase == PHASE_CODE_BLOCK) begin
            send_item(1'b0, BYTE_ACK);
            wait_drained();
         end
      end
      send_item(1'b0, BYTE_CRC);
      send_item(1'b0, noise_byte(1'b0));
      wait_drained();
      if (limit_ending)
         csr_write(REG_MAX_RETRIES, 32'($urandom_range(0, 2)));
      bumps = board.retries;
      if (limit_ending) begin
         while (bumps < board.retry_limit) begin
            send_retry_trigger();
            bumps++;
         end
      end else begin
         repeat ($urandom_range(0, 2)) begin
            if (bumps < board.retry_limit) begin
               send_retry_trigger();
               bumps++;
            end
         end
      end
      case (ending)
         ERR_NONE:                        send_item(1'b0, BYTE_ACK);
         ERR_BLOCK_NAK, ERR_EOT_NAK:       send_item(1'b0, BYTE_NAK);
         ERR_BLOCK_CANCEL, ERR_EOT_CANCEL: send_item(1'b0, BYTE_CAN);
         default:                         send_item(1'b1, 8'($urandom_range(0, 255)));
      endcase

      // Once finished, nothing moves the transfer any more.
      send_item(1'b1, 8'($urandom_range(0, 255)));
      send_item(1'b0, BYTE_ACK);
      send_item(1'b0, BYTE_NAK);
      send_item(1'b0, BYTE_CAN);
      send_item(1'b0, BYTE_CRC);
      wait_drained();
      repeat (8) @(posedge clock);

      $display("Run covered %0d request transactions and %0d checked results, %0d bytes acked.",
               board.accepted, board.checked, board.acked);
      $display("Block number wrapped %0d times; transfer ended in phase %0d, error code %0d.",
               board.wraps, board.phase, board.last_error);
      if (board.mismatches == 0 && board.expected_q.size() == 0) begin
         $display("Verification passed");
      end else begin
         $display("%0d mismatches, %0d results missing", board.mismatches,
                  board.expected_q.size());
         $display("Verification failed");
      end
      $finish;
   end

endmodule
